[sv/ssm_pkg.sv]
package ssm_pkg;

   localparam int MaxSegmentsDefault = 64;
   localparam int WidthBitsDefault   = 16;
   localparam int YBits              = 24;
   localparam logic [YBits-1:0] YMax = {YBits{1'b1}};

   typedef enum logic [1:0] {
      OP_PACK  = 2'd0,
      OP_ERASE = 2'd1,
      OP_QUERY = 2'd2,
      OP_QALT  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_WIDE  = 2'd1,
      ST_INDEX = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [5:0]  segment_index;
      logic [15:0] rect_width;
      logic [15:0] rect_height;
      logic        side_choice;
   } req_type;

   typedef struct packed {
      logic [15:0] place_x;
      logic [23:0] place_y;
      logic [5:0]  lowest_index;
      logic [6:0]  segment_total;
      logic [1:0]  status;
   } rsp_type;

   // chain commands
   typedef enum logic [2:0] {
      CH_HOLD  = 3'd0,
      CH_WRITE = 3'd1,
      CH_OPEN  = 3'd2,
      CH_REM1  = 3'd3,
      CH_REM2  = 3'd4
   } chain_op_type;

   function automatic logic [YBits-1:0] pos_diff(input logic [YBits-1:0] a,
                                                 input logic [YBits-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   function automatic logic [YBits-1:0] add_y(input logic [YBits-1:0] a,
                                              input logic [YBits-1:0] b);
      logic [YBits:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[YBits] ? YMax : s[YBits-1:0];
   endfunction

endpackage

[sv/ssm_cell.sv]
module ssm_cell import ssm_pkg::*; #(
   parameter int WidthBits = WidthBitsDefault
) (
   input  logic                 clock,
   input  logic                 active,
   input  logic                 load,
   input  logic [WidthBits-1:0] load_x,
   input  logic [YBits-1:0]     load_y,
   input  logic [WidthBits-1:0] load_w,
   input  logic [YBits-1:0]     load_l,
   input  logic [YBits-1:0]     load_r,
   input  logic                 shift,
   input  logic [WidthBits-1:0] nb_x,
   input  logic [YBits-1:0]     nb_y,
   input  logic [WidthBits-1:0] nb_w,
   input  logic [YBits-1:0]     nb_l,
   input  logic [YBits-1:0]     nb_r,
   output logic [WidthBits-1:0] x_ff,
   output logic [YBits-1:0]     y_ff,
   output logic [WidthBits-1:0] w_ff,
   output logic [YBits-1:0]     l_ff,
   output logic [YBits-1:0]     r_ff
);

   // one segment; takes a direct write or its neighbor's contents
   always_ff @(posedge clock) begin
      if (active && load) begin
         x_ff <= load_x; y_ff <= load_y; w_ff <= load_w;
         l_ff <= load_l; r_ff <= load_r;
      end else if (active && shift) begin
         x_ff <= nb_x; y_ff <= nb_y; w_ff <= nb_w;
         l_ff <= nb_l; r_ff <= nb_r;
      end
   end

endmodule

[sv/skyline_segment_manager_top.sv]
// Skyline segment manager. An item on req_item (start while busy is low) packs,
// erases or queries; exactly one result follows on rsp_item with rsp_valid high
// for one cycle. After the accepting edge busy stays high while the block reads
// the left, center and right segments through a shared segment mux, goes through
// an edit step and, when the item removes segments, then shifts the chain (an item
// that adds a segment shifts the chain before the edit), then runs a lowest-leftmost
// scan that walks the cell chain one segment per cycle over the segments left
// after the item. The result is shown in the last busy cycle. A csr_ write
// restarts the skyline as one segment of the new width and takes effect at once.
// The receiver cannot stall: results must be taken when shown.
module skyline_segment_manager_top import ssm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        csr_write,
   input  logic [15:0] csr_data
);

   localparam int MaxSegments = MaxSegmentsDefault;
   localparam int WidthBits   = WidthBitsDefault;
   localparam int IB = $clog2(MaxSegments);
   localparam int CB = $clog2(MaxSegments + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_RD0   = 8'b00000010,
      S_RD1   = 8'b00000100,
      S_RD2   = 8'b00001000,
      S_EDIT  = 8'b00010000,
      S_SHIFT = 8'b00100000,
      S_SCAN  = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   logic [WidthBits-1:0] cx [MaxSegments];
   logic [YBits-1:0]     cy [MaxSegments];
   logic [WidthBits-1:0] cw [MaxSegments];
   logic [YBits-1:0]     cl [MaxSegments];
   logic [YBits-1:0]     cr [MaxSegments];

   logic [CB-1:0]  count_ff;
   req_type        req_ff;
   logic [1:0]     status_ff;
   logic [15:0]    px_ff;
   logic [23:0]    py_ff;
   logic [IB-1:0]  scan_ff, best_ff;
   logic [1:0]     rd_ff;
   chain_op_type   chop_ff;
   logic [IB-1:0]  chat_ff;

   // captured neighborhood: index 0 left, 1 center, 2 right
   logic [WidthBits-1:0] nx [3];
   logic [YBits-1:0]     ny [3];
   logic [WidthBits-1:0] nw [3];
   logic [YBits-1:0]     nl [3];
   logic [YBits-1:0]     nr [3];

   // pending writes, up to three cells
   logic          wen   [3];
   logic [IB-1:0] wadr  [3];
   logic [WidthBits-1:0] wx [3];
   logic [YBits-1:0]     wy [3];
   logic [WidthBits-1:0] ww [3];
   logic [YBits-1:0]     wl [3];
   logic [YBits-1:0]     wr [3];

   // shared read mux of the chain
   logic [IB-1:0] rd_idx;
   logic [WidthBits-1:0] m_x, m_w;
   logic [YBits-1:0]     m_y, m_l, m_r;
   assign m_x = cx[rd_idx];
   assign m_y = cy[rd_idx];
   assign m_w = cw[rd_idx];
   assign m_l = cl[rd_idx];
   assign m_r = cr[rd_idx];

   logic [IB-1:0] idx_ext;
   assign idx_ext = req_ff.segment_index[IB-1:0];
   always_comb begin
      unique case (rd_ff)
         2'd0: rd_idx = idx_ext - 1'b1;
         2'd1: rd_idx = idx_ext;
         default: rd_idx = idx_ext + 1'b1;
      endcase
      if (state_ff == S_SCAN) rd_idx = scan_ff;
   end

   // cell row
   logic [WidthBits-1:0] ld_x [MaxSegments];
   logic [YBits-1:0]     ld_y [MaxSegments];
   logic [WidthBits-1:0] ld_w [MaxSegments];
   logic [YBits-1:0]     ld_l [MaxSegments];
   logic [YBits-1:0]     ld_r [MaxSegments];
   logic                 ld   [MaxSegments];
   logic                 sh   [MaxSegments];
   logic [WidthBits-1:0] sx [MaxSegments];
   logic [YBits-1:0]     sy [MaxSegments];
   logic [WidthBits-1:0] sw [MaxSegments];
   logic [YBits-1:0]     sl [MaxSegments];
   logic [YBits-1:0]     sr [MaxSegments];
   logic init_go;
   assign init_go = reset || csr_write;

   for (genvar g = 0; g < MaxSegments; g++) begin : g_cell
      always_comb begin
         ld[g] = 1'b0;
         ld_x[g] = '0; ld_y[g] = '0; ld_w[g] = '0; ld_l[g] = '0; ld_r[g] = '0;
         if (g == 0 && init_go) begin
            ld[g] = 1'b1;
            ld_w[g] = reset ? WidthBits'(1024) : WidthBits'(csr_data);
         end else if (!init_go && state_ff == S_EDIT) begin
            for (int k = 0; k < 3; k++) begin
               if (wen[k] && wadr[k] == IB'(g)) begin
                  ld[g] = 1'b1;
                  ld_x[g] = wx[k]; ld_y[g] = wy[k]; ld_w[g] = ww[k];
                  ld_l[g] = wl[k]; ld_r[g] = wr[k];
               end
            end
         end
         // shift: open moves data right (from g-1), remove from g+1 or g+2
         sh[g] = 1'b0;
         sx[g] = cx[g]; sy[g] = cy[g]; sw[g] = cw[g]; sl[g] = cl[g]; sr[g] = cr[g];
         if (!init_go && state_ff == S_SHIFT) begin
            if (chop_ff == CH_OPEN && g > 0 && IB'(g) > chat_ff) begin
               sh[g] = 1'b1;
               sx[g] = cx[(g+MaxSegments-1)%MaxSegments];
               sy[g] = cy[(g+MaxSegments-1)%MaxSegments];
               sw[g] = cw[(g+MaxSegments-1)%MaxSegments];
               sl[g] = cl[(g+MaxSegments-1)%MaxSegments];
               sr[g] = cr[(g+MaxSegments-1)%MaxSegments];
            end else if (chop_ff == CH_REM1 && IB'(g) >= chat_ff) begin
               sh[g] = 1'b1;
               sx[g] = cx[(g+1)%MaxSegments]; sy[g] = cy[(g+1)%MaxSegments];
               sw[g] = cw[(g+1)%MaxSegments]; sl[g] = cl[(g+1)%MaxSegments];
               sr[g] = cr[(g+1)%MaxSegments];
            end else if (chop_ff == CH_REM2 && IB'(g) >= chat_ff) begin
               sh[g] = 1'b1;
               sx[g] = cx[(g+2)%MaxSegments]; sy[g] = cy[(g+2)%MaxSegments];
               sw[g] = cw[(g+2)%MaxSegments]; sl[g] = cl[(g+2)%MaxSegments];
               sr[g] = cr[(g+2)%MaxSegments];
            end
         end
      end
      ssm_cell #(.WidthBits(WidthBits)) u_cell (
         .clock(clock), .active(1'b1), .load(ld[g]),
         .load_x(ld_x[g]), .load_y(ld_y[g]), .load_w(ld_w[g]),
         .load_l(ld_l[g]), .load_r(ld_r[g]),
         .shift(sh[g]), .nb_x(sx[g]), .nb_y(sy[g]), .nb_w(sw[g]),
         .nb_l(sl[g]), .nb_r(sr[g]),
         .x_ff(cx[g]), .y_ff(cy[g]), .w_ff(cw[g]), .l_ff(cl[g]), .r_ff(cr[g]));
   end

   // decision logic: from captured neighborhood build writes and chain op
   logic hasl, hasr;
   logic [WidthBits-1:0] w, wi;
   logic [YBits-1:0] h, h1, h2, yi_new;
   logic [1:0] st;
   chain_op_type chop;
   logic [IB-1:0] chat;
   logic [CB-1:0] count_new;
   logic [15:0] pxv;
   logic [23:0] pyv;
   logic [IB-1:0] i0, il, ir;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         wen[k] = 1'b0; wadr[k] = '0;
         wx[k] = nx[k]; wy[k] = ny[k]; ww[k] = nw[k]; wl[k] = nl[k]; wr[k] = nr[k];
      end
      i0 = req_ff.segment_index[IB-1:0];
      il = i0 - 1'b1;
      ir = i0 + 1'b1;
      wadr[0] = il; wadr[1] = i0; wadr[2] = ir;
      hasl = (i0 != '0);
      hasr = (CB'(ir) < count_ff) && (ir != '0);
      w = WidthBits'(req_ff.rect_width);
      h = YBits'(req_ff.rect_height);
      wi = nw[1];
      h1 = nl[1];
      h2 = nr[1];
      yi_new = add_y(ny[1], h);
      st = ST_OK;
      chop = CH_HOLD;
      chat = i0;
      count_new = count_ff;
      pxv = '0;
      pyv = '0;
      if ((req_ff.operation == OP_PACK || req_ff.operation == OP_ERASE) &&
          (CB'(req_ff.segment_index) >= count_ff ||
           32'(req_ff.segment_index) >= MaxSegments)) begin
         st = ST_INDEX;
      end else if (req_ff.operation == OP_PACK) begin
         if (w > wi) st = ST_WIDE;
         else if (w != wi && h != h1 && h != h2 && 32'(count_ff) >= MaxSegments)
            st = ST_FULL;
         else begin
            pxv = 16'(nx[1]);
            pyv = ny[1];
            chop = CH_WRITE;
            if (w == wi) begin
               if (h == h1) begin
                  if (hasl) begin
                     wen[0] = 1'b1;
                     ww[0] = nw[0] + wi;
                     wr[0] = hasr ? pos_diff(ny[2], ny[0]) : '0;
                     if (h1 == h2 && hasr) begin
                        ww[0] = nw[0] + wi + nw[2];
                        wr[0] = nr[2];
                        chop = CH_REM2;
                        count_new = count_ff - 2'd2;
                     end else begin
                        if (hasr) begin wen[2] = 1'b1; wl[2] = pos_diff(h, h2); end
                        chop = CH_REM1;
                        count_new = count_ff - 1'b1;
                     end
                  end
               end else if (h == h2) begin
                  if (hasr) begin
                     wen[2] = 1'b1;
                     ww[2] = nw[2] + wi;
                     wl[2] = hasl ? pos_diff(ny[0], ny[2]) : '0;
                     wx[2] = nx[1];
                     if (hasl) begin wen[0] = 1'b1; wr[0] = pos_diff(h, h1); end
                     chop = CH_REM1;
                     count_new = count_ff - 1'b1;
                  end
               end else if (h > h1 && h > h2) begin
                  wen[1] = 1'b1; wy[1] = yi_new; wl[1] = '0; wr[1] = '0;
                  if (hasl) begin wen[0] = 1'b1; wr[0] = pos_diff(yi_new, ny[0]); end
                  if (hasr) begin wen[2] = 1'b1; wl[2] = pos_diff(yi_new, ny[2]); end
               end else if (h > ((h1 < h2) ? h1 : h2) && h < ((h1 > h2) ? h1 : h2)) begin
                  wen[1] = 1'b1; wy[1] = yi_new;
                  if (h1 > h2) begin
                     if (hasr) begin wen[2] = 1'b1; wl[2] = pos_diff(yi_new, ny[2]); end
                     wl[1] = hasl ? pos_diff(ny[0], yi_new) : '0;
                     wr[1] = '0;
                  end else begin
                     if (hasl) begin wen[0] = 1'b1; wr[0] = pos_diff(yi_new, ny[0]); end
                     wr[1] = hasr ? pos_diff(ny[2], yi_new) : '0;
                     wl[1] = '0;
                  end
               end else begin
                  wen[1] = 1'b1; wy[1] = yi_new;
                  wl[1] = pos_diff(h1, h); wr[1] = pos_diff(h2, h);
               end
            end else if (h == h1) begin
               if (hasl) begin
                  wen[0] = 1'b1; ww[0] = nw[0] + w; wr[0] = '0;
                  wen[1] = 1'b1; wx[1] = nx[1] + w; ww[1] = wi - w; wl[1] = h;
               end
            end else if (h == h2) begin
               if (hasr) begin
                  pxv = 16'(pos_diff(YBits'(nx[2]), YBits'(w)));
                  wen[2] = 1'b1; ww[2] = nw[2] + w; wl[2] = '0;
                  wx[2] = WidthBits'(pos_diff(YBits'(nx[2]), YBits'(w)));
                  wen[1] = 1'b1; ww[1] = wi - w; wr[1] = h;
               end
            end else if (req_ff.side_choice) begin
               // left placement: cell i keeps the rectangle, new cell at i+1
               if (hasl) begin wen[0] = 1'b1; wr[0] = pos_diff(h, h1); end
               chop = CH_OPEN; chat = i0; count_new = count_ff + 1'b1;
               wen[2] = 1'b1; wx[2] = nx[1] + w; wy[2] = ny[1]; wl[2] = h;
               wr[2] = h2; ww[2] = wi - w;
               wen[1] = 1'b1; wl[1] = pos_diff(h1, h); wr[1] = '0; ww[1] = w;
               wy[1] = yi_new;
            end else begin
               // right placement: remainder at i, rectangle at i+1
               pxv = 16'(nx[1] + (wi - w));
               chop = CH_OPEN; chat = i0; count_new = count_ff + 1'b1;
               wen[1] = 1'b1; wl[1] = h1; wr[1] = h; ww[1] = wi - w;
               wen[2] = 1'b1; wx[2] = nx[1] + (wi - w); wy[2] = yi_new;
               wl[2] = '0; wr[2] = pos_diff(h2, h); ww[2] = w;
               // old right neighbor sits two cells up after the open
               if (hasr) begin
                  wen[0] = 1'b1; wadr[0] = i0 + 2'd2;
                  wx[0] = nx[2]; wy[0] = ny[2]; ww[0] = nw[2];
                  wl[0] = pos_diff(h, h2); wr[0] = nr[2];
               end
            end
         end
      end else if (req_ff.operation == OP_ERASE) begin
         if (count_ff < CB'(2)) st = ST_FULL;
         else begin
            count_new = count_ff - 1'b1;
            chop = CH_REM1;
            if (hasl && hasr && ny[2] == ny[0]) begin
               wen[0] = 1'b1; ww[0] = nw[0] + nw[1] + nw[2]; wr[0] = nr[2];
               chop = CH_REM2; count_new = count_ff - 2'd2;
            end else if (hasl && (!hasr || ny[2] > ny[0])) begin
               wen[0] = 1'b1; ww[0] = nw[0] + nw[1];
               wr[0] = hasr ? ny[2] - ny[0] : '0;
            end else begin
               wen[2] = 1'b1; ww[2] = nw[2] + nw[1]; wx[2] = nx[1];
               wl[2] = hasl ? pos_diff(ny[0], ny[2]) : '0;
            end
         end
      end
      // an open places its own cells; elsewhere missing neighbors take no write
      if (chop != CH_OPEN) begin
         if (!hasl) wen[0] = 1'b0;
         if (!hasr) wen[2] = 1'b0;
      end
   end

   // the write phase writes cells first, so the open shift must come before
   // the write: reorder open writes to land after the shift
   logic open_pend_ff;

   // control sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (start) state_in = S_RD0;
         S_RD0:   state_in = S_RD1;
         S_RD1:   state_in = S_RD2;
         S_RD2:   state_in = (chop == CH_OPEN) ? S_SHIFT : S_EDIT;
         S_EDIT:  state_in = (chop_ff == CH_REM1 || chop_ff == CH_REM2) ? S_SHIFT : S_SCAN;
         S_SHIFT: state_in = open_pend_ff ? S_EDIT : S_SCAN;
         S_SCAN:  if ({1'b0, scan_ff} + 1'b1 >= (IB+1)'(count_ff)) state_in = S_OUT;
         S_OUT:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         state_ff <= S_IDLE;
         count_ff <= CB'(1);
         open_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            S_IDLE: if (start) begin req_ff <= req_item; rd_ff <= 2'd0; end
            S_RD0, S_RD1, S_RD2: begin
               nx[rd_ff] <= m_x; ny[rd_ff] <= m_y; nw[rd_ff] <= m_w;
               nl[rd_ff] <= m_l; nr[rd_ff] <= m_r;
               rd_ff <= rd_ff + 1'b1;
               if (state_ff == S_RD2) begin
                  // center and left are ready; right arrives now
                  open_pend_ff <= (chop == CH_OPEN);
               end
            end
            S_EDIT: begin
               open_pend_ff <= 1'b0;
               count_ff <= count_new;
            end
            default: ;
         endcase
      end
      if (state_ff == S_EDIT) begin
         status_ff <= st;
         px_ff <= pxv;
         py_ff <= pyv;
         chop_ff <= chop;
         chat_ff <= chat;
         scan_ff <= '0; best_ff <= '0;
      end
      if (state_ff == S_RD2) begin
         chop_ff <= chop; chat_ff <= i0;
      end
      if (state_ff == S_SHIFT) begin
         scan_ff <= '0; best_ff <= '0;
      end
      if (state_ff == S_SCAN) begin
         if (cy[scan_ff] < cy[best_ff] ||
             (cy[scan_ff] == cy[best_ff] && cx[scan_ff] < cx[best_ff]))
            best_ff <= scan_ff;
         scan_ff <= scan_ff + 1'b1;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   always_comb begin
      rsp_item = '0;
      rsp_item.place_x = px_ff;
      rsp_item.place_y = py_ff;
      rsp_item.lowest_index = 6'(best_ff);
      rsp_item.segment_total = 7'(count_ff);
      rsp_item.status = status_ff;
   end

endmodule

[sv/ssm_checker.sv]
module ssm_checker import ssm_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item did not raise busy");
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe held");
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside an item");
   a_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.segment_total != 7'd0) else $error("empty skyline");

endmodule

bind skyline_segment_manager_top ssm_checker u_ssm_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_item(rsp_item));
